// ----- hw/rtl/svpwm_mmd_pkg.sv -----
// Shared types, constants and the radix-16 divide step for the SVPWM duty pipeline.
package svpwm_mmd_pkg;

    // Item and lane geometry
    localparam int LANES   = 3;
    localparam int DATA_W  = 16;
    localparam int VOLT_W  = 33;   // phase voltage, 2^-24 V units
    localparam int COM_W   = 34;   // vmax + vmin
    localparam int NUM_W   = 37;   // duty numerator, signed
    localparam int DVS_W   = 17;   // divisor 2*B
    localparam int QSTEP   = 4;    // quotient bits resolved per stage
    localparam int LOW_W   = 12;   // numerator bits still to shift in after the first stage
    localparam int DIV_STG = 3;    // divide stages ahead of the output stage
    localparam int STAGES  = 7;    // total register stages

    // sqrt(3)/2 in Q16, held as a positive signed constant
    localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;
    localparam logic [DATA_W-1:0]  BUS_MIN        = 16'd256;
    localparam logic [DATA_W-1:0]  DUTY_MAX       = 16'hFFFF;

    typedef logic signed [VOLT_W-1:0] volt_t;
    typedef logic signed [COM_W-1:0]  com_t;
    typedef logic signed [NUM_W-1:0]  num_t;

    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [QSTEP-1:0] qbits;
    } div_step_t;

    // Four restoring long-division steps: partial remainder stays below the divisor
    function automatic div_step_t div4(
        input logic [DVS_W-1:0] rem_in,
        input logic [QSTEP-1:0] bits_in,
        input logic [DVS_W-1:0] dvs
    );
        logic [DVS_W:0]   trial;
        logic [DVS_W-1:0] r;
        logic [QSTEP-1:0] q;
        div_step_t        res;
        r = rem_in;
        q = '0;
        for (int i = QSTEP - 1; i >= 0; i--)
        begin
            trial = {r, bits_in[i]};
            if (trial >= {1'b0, dvs})
            begin
                trial = trial - {1'b0, dvs};
                q[i]  = 1'b1;
            end
            r = trial[DVS_W-1:0];
        end
        res.rem   = r;
        res.qbits = q;
        return res;
    endfunction

endpackage

// ----- hw/rtl/svpwm_min_max_duty.sv -----
// SVPWM duty generator: inverse Clarke, min-max injection, bus normalization, pipelined.
//
//   channel   dir  handshake                    payload (low bit first)
//   s_axis    in   s_axis_tvalid/s_axis_tready  alpha_voltage, beta_voltage, bus_voltage
//   m_axis    out  m_axis_tvalid/m_axis_tready  duty_u, duty_v, duty_w
//
// Seven register stages: multiply, min/max, numerator, three divide stages of four
// quotient bits each, and an output stage with the last four bits and saturation.
// One item enters and one leaves per cycle when not stalled.
// Reset clears the stage valid bits only; payload registers are not reset.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and a stalled output holds its item while earlier stages keep filling.
module svpwm_min_max_duty
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // alpha_voltage[15:0], beta_voltage[31:16], bus_voltage[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // duty_u[15:0], duty_v[31:16], duty_w[47:32]
);

    localparam int NL = svpwm_mmd_pkg::LANES;
    localparam int NS = svpwm_mmd_pkg::STAGES;
    localparam int ND = svpwm_mmd_pkg::DIV_STG;
    localparam int DW = svpwm_mmd_pkg::DATA_W;
    localparam int VW = svpwm_mmd_pkg::VOLT_W;
    localparam int CW = svpwm_mmd_pkg::COM_W;
    localparam int NW = svpwm_mmd_pkg::NUM_W;
    localparam int RW = svpwm_mmd_pkg::DVS_W;
    localparam int QS = svpwm_mmd_pkg::QSTEP;
    localparam int LW = svpwm_mmd_pkg::LOW_W;

    // Stage valid bits and per-stage advance
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = ~vld_reg[NS-1] | m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = ~vld_reg[k] | adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: inverse Clarke products, bus clamp
    logic signed [DW-1:0]      alpha_s;
    logic signed [DW-1:0]      beta_s;
    svpwm_mmd_pkg::volt_t      alpha_half;
    svpwm_mmd_pkg::volt_t      beta_prod;
    svpwm_mmd_pkg::volt_t      s0_v_next [NL];
    logic [DW-1:0]             s0_bus_next;
    svpwm_mmd_pkg::volt_t      s0_v_reg  [NL];
    logic [DW-1:0]             s0_bus_reg;

    always_comb
    begin
        alpha_s      = $signed(s_axis_tdata[15:0]);
        beta_s       = $signed(s_axis_tdata[31:16]);
        alpha_half   = {{2{alpha_s[DW-1]}}, alpha_s, 15'b0};
        beta_prod    = beta_s * svpwm_mmd_pkg::SQRT3_HALF_Q16;
        s0_v_next[0] = {alpha_s[DW-1], alpha_s, 16'b0};
        s0_v_next[1] = beta_prod - alpha_half;
        s0_v_next[2] = (-beta_prod) - alpha_half;
        s0_bus_next  = (s_axis_tdata[47:32] < svpwm_mmd_pkg::BUS_MIN) ?
                       svpwm_mmd_pkg::BUS_MIN : s_axis_tdata[47:32];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_v_reg   <= s0_v_next;
            s0_bus_reg <= s0_bus_next;
        end
    end

    // Stage 1: phase max and min, their sum
    svpwm_mmd_pkg::volt_t vmax;
    svpwm_mmd_pkg::volt_t vmin;
    svpwm_mmd_pkg::com_t  s1_com_next;
    svpwm_mmd_pkg::volt_t s1_v_reg [NL];
    svpwm_mmd_pkg::com_t  s1_com_reg;
    logic [DW-1:0]        s1_bus_reg;

    always_comb
    begin
        vmax = s0_v_reg[0];
        vmin = s0_v_reg[0];
        for (int l = 1; l < NL; l++)
        begin
            if (s0_v_reg[l] > vmax)
            begin
                vmax = s0_v_reg[l];
            end
            if (s0_v_reg[l] < vmin)
            begin
                vmin = s0_v_reg[l];
            end
        end
        s1_com_next = CW'(vmax) + CW'(vmin);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_v_reg   <= s0_v_reg;
            s1_com_reg <= s1_com_next;
            s1_bus_reg <= s0_bus_reg;
        end
    end

    // Stage 2: numerator 2*v - (vmax+vmin) + 65537*B
    svpwm_mmd_pkg::num_t bus_term;
    svpwm_mmd_pkg::num_t s2_num_next [NL];
    svpwm_mmd_pkg::num_t s2_num_reg  [NL];
    logic [DW-1:0]       s2_bus_reg;

    always_comb
    begin
        bus_term = $signed({{(NW-DW-16){1'b0}}, s1_bus_reg, 16'b0})
                 + $signed({{(NW-DW){1'b0}}, s1_bus_reg});
        for (int l = 0; l < NL; l++)
        begin
            s2_num_next[l] = (NW'(s1_v_reg[l]) <<< 1) - NW'(s1_com_reg) + bus_term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_num_reg <= s2_num_next;
            s2_bus_reg <= s1_bus_reg;
        end
    end

    // Stages 3..5: long division by 2*B, four quotient bits per stage
    logic [RW-1:0]           dv_rem_next [ND][NL];
    logic [DW-1:0]           dv_q_next   [ND][NL];
    logic [LW-1:0]           dv_low_next [ND][NL];
    logic                    dv_neg_next [ND][NL];
    logic                    dv_sat_next [ND][NL];
    logic [RW-1:0]           dv_dvs_next [ND];
    logic [RW-1:0]           dv_rem_reg  [ND][NL];
    logic [DW-1:0]           dv_q_reg    [ND][NL];
    logic [LW-1:0]           dv_low_reg  [ND][NL];
    logic                    dv_neg_reg  [ND][NL];
    logic                    dv_sat_reg  [ND][NL];
    logic [RW-1:0]           dv_dvs_reg  [ND];
    svpwm_mmd_pkg::div_step_t dv_step;
    svpwm_mmd_pkg::num_t      num_cur;

    always_comb
    begin
        for (int j = 0; j < ND; j++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                if (j == 0)
                begin
                    // negative numerator gives zero; num >= B*2^17 gives full scale
                    num_cur           = s2_num_reg[l];
                    dv_dvs_next[j]    = {s2_bus_reg, 1'b0};
                    dv_neg_next[j][l] = num_cur[NW-1];
                    dv_sat_next[j][l] = ~num_cur[NW-1]
                                      && (num_cur[NW-2:17] >= (NW-18)'(s2_bus_reg));
                    dv_step           = svpwm_mmd_pkg::div4(num_cur[32:16], num_cur[15:12],
                                                            {s2_bus_reg, 1'b0});
                    dv_q_next[j][l]   = {{(DW-QS){1'b0}}, dv_step.qbits};
                    dv_low_next[j][l] = num_cur[LW-1:0];
                end
                else
                begin
                    num_cur           = '0;
                    dv_dvs_next[j]    = dv_dvs_reg[j-1];
                    dv_neg_next[j][l] = dv_neg_reg[j-1][l];
                    dv_sat_next[j][l] = dv_sat_reg[j-1][l];
                    dv_step           = svpwm_mmd_pkg::div4(dv_rem_reg[j-1][l],
                                            dv_low_reg[j-1][l][LW-1 -: QS], dv_dvs_reg[j-1]);
                    dv_q_next[j][l]   = {dv_q_reg[j-1][l][DW-QS-1:0], dv_step.qbits};
                    dv_low_next[j][l] = {dv_low_reg[j-1][l][LW-QS-1:0], {QS{1'b0}}};
                end
                dv_rem_next[j][l] = dv_step.rem;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ND; j++)
        begin
            if (adv[3+j])
            begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
                dv_low_reg[j] <= dv_low_next[j];
                dv_neg_reg[j] <= dv_neg_next[j];
                dv_sat_reg[j] <= dv_sat_next[j];
                dv_dvs_reg[j] <= dv_dvs_next[j];
            end
        end
    end

    // Stage 6: last quotient bits and saturation into the output register
    svpwm_mmd_pkg::div_step_t out_step;
    logic [DW-1:0]            out_q;
    logic [DW-1:0]            duty_next [NL];
    logic [DW-1:0]            duty_reg  [NL];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            out_step = svpwm_mmd_pkg::div4(dv_rem_reg[ND-1][l],
                                           dv_low_reg[ND-1][l][LW-1 -: QS], dv_dvs_reg[ND-1]);
            out_q    = {dv_q_reg[ND-1][l][DW-QS-1:0], out_step.qbits};
            if (dv_neg_reg[ND-1][l])
            begin
                duty_next[l] = '0;
            end
            else if (dv_sat_reg[ND-1][l])
            begin
                duty_next[l] = svpwm_mmd_pkg::DUTY_MAX;
            end
            else
            begin
                duty_next[l] = out_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            duty_reg <= duty_next;
        end
    end

    assign m_axis_tdata = {duty_reg[2], duty_reg[1], duty_reg[0]};

endmodule
